// File: rtl/core/tmq_pkg.sv
// ----------------------------------------------------------------------------
// Tridiagonal matrix-vector product package
// Shared widths and the job record passed from the front end to the
// arithmetic back end.
// ----------------------------------------------------------------------------
package tmq_pkg;

  // Field widths of the stream.
  localparam int unsigned ElemW  = 32;
  localparam int unsigned ProdW  = 48;
  localparam int unsigned QuadW  = 64;

  // Configuration register indexes.
  localparam logic RegNextCoef = 1'b0;
  localparam logic RegPrevCoef = 1'b1;

  // Depth of the job queue between the front and back ends.
  localparam int unsigned JobDepth = 2;

  // One product element to compute: diag*elem + next_coef*nbr_next +
  // prev_coef*nbr_prev. A missing neighbor is carried as zero. The
  // quadratic term always uses elem as its vector element.
  typedef struct packed {
    logic signed [ElemW-1:0] diag;
    logic signed [ElemW-1:0] elem;
    logic signed [ElemW-1:0] nbr_next;
    logic signed [ElemW-1:0] nbr_prev;
    logic                    fin;
  } job_t;

endpackage

// File: rtl/core/tridiag_matvec_quadform.sv
// ----------------------------------------------------------------------------
// Tridiagonal matrix-vector product with quadratic form
// Streams v[i] with diag[i] and returns A*v element by element together
// with the running quadratic form v'Av.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = {diag_elem, vec_elem}, tlast marks the last vector
//   element. Master stream: tdata = {quad_sum, prod_elem}, tlast marks the
//   final product element, on which quad_sum is the full v'Av.
//   The configuration port writes next_coef (index 0) and prev_coef
//   (index 1); write only while no vector is in flight. Swapping the two
//   coefficients gives the transposed product.
//   Product element i appears once element i+1 is accepted; the last input
//   gives two results, a vector of length one gives diag*v.
//   An element that completes a result passes through the job queue, the
//   arithmetic pipe and the output register before that result reaches the
//   master side.
//   Throughput is one item per cycle while the master side does not stall;
//   tready drops after the last item of a vector of two or more elements
//   while its closing job is held, as its two jobs enter one at a time.
//   Reset clears the coefficients, the stream state and the running sum.
//   When the receiver stalls, the back-end pipe holds, the two-entry job
//   queue fills, and then the slave side deasserts tready.
// ----------------------------------------------------------------------------
module tridiag_matvec_quadform #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write port.
  input  logic          cfg_we_i,
  input  logic          cfg_addr_i,
  input  logic [31:0]   cfg_wdata_i,
  // Slave stream.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // [31:0] vec_elem, [63:32] diag_elem
  input  logic          s_axis_tlast,   // is_last
  // Master stream.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // [47:0] prod_elem, [111:48] quad_sum
  output logic          m_axis_tlast    // is_final
);
  import tmq_pkg::*;

  logic [31:0] next_coef_q, prev_coef_q;
  logic        push, full, pop, empty;
  job_t        front_job, head_job;
  logic [47:0] prod_elem;
  logic [63:0] quad_sum;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_coef_q <= '0;
      prev_coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegNextCoef: next_coef_q <= cfg_wdata_i;
        RegPrevCoef: prev_coef_q <= cfg_wdata_i;
        default:     next_coef_q <= next_coef_q;
      endcase
    end
  end

  tmq_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .vec_elem_i (s_axis_tdata[31:0]),
    .diag_elem_i(s_axis_tdata[63:32]),
    .is_last_i  (s_axis_tlast),
    .push_o     (push),
    .job_o      (front_job),
    .full_i     (full)
  );

  tmq_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (head_job)
  );

  tmq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .next_coef_i(next_coef_q),
    .prev_coef_i(prev_coef_q),
    .empty_i    (empty),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .prod_elem_o(prod_elem),
    .quad_sum_o (quad_sum),
    .is_final_o (m_axis_tlast)
  );

  assign m_axis_tdata = {quad_sum, prod_elem};

endmodule

// File: rtl/core/tmq_front.sv
// ----------------------------------------------------------------------------
// Tridiagonal product front end
// Accepts vector elements, tracks the previous and pending elements and
// turns each arrival into zero, one or two product jobs.
// ----------------------------------------------------------------------------
module tmq_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         vec_elem_i,
  input  logic [31:0]         diag_elem_i,
  input  logic                is_last_i,
  output logic                push_o,
  output tmq_pkg::job_t       job_o,
  input  logic                full_i
);
  import tmq_pkg::*;

  localparam int unsigned SextW  = (DATA_WIDTH < ElemW) ? DATA_WIDTH : ElemW;
  localparam int unsigned SextSh = ElemW - SextW;

  logic signed [ElemW-1:0] older_q, older_d;
  logic                    older_vld_q, older_vld_d;
  logic signed [ElemW-1:0] pend_elem_q, pend_elem_d;
  logic signed [ElemW-1:0] pend_diag_q, pend_diag_d;
  logic                    pend_vld_q, pend_vld_d;
  logic                    hold_vld_q, hold_vld_d;
  job_t                    hold_job_q, hold_job_d;

  logic signed [ElemW-1:0] vec_sh, diag_sh, x, d;
  logic                    acc;
  job_t                    job_a, job_b;

  // Sign-extend the inputs from the configured element width.
  assign vec_sh  = vec_elem_i << SextSh;
  assign diag_sh = diag_elem_i << SextSh;
  assign x       = vec_sh >>> SextSh;
  assign d       = diag_sh >>> SextSh;

  assign in_ready_o = !hold_vld_q && !full_i;
  assign acc        = in_valid_i && in_ready_o;

  // Job for the pending element (or for a vector of length one), and the
  // closing job for the last element when something was pending.
  always_comb begin
    if (pend_vld_q) begin
      job_a.diag     = pend_diag_q;
      job_a.elem     = pend_elem_q;
      job_a.nbr_next = x;
      job_a.nbr_prev = older_vld_q ? older_q : '0;
      job_a.fin      = 1'b0;
    end else begin
      job_a.diag     = d;
      job_a.elem     = x;
      job_a.nbr_next = '0;
      job_a.nbr_prev = '0;
      job_a.fin      = 1'b1;
    end
    job_b.diag     = d;
    job_b.elem     = x;
    job_b.nbr_next = '0;
    job_b.nbr_prev = pend_elem_q;
    job_b.fin      = 1'b1;
  end

  // Queue write: a held closing job has priority; no input is taken then.
  assign push_o = hold_vld_q ? !full_i : (acc && (pend_vld_q || is_last_i));
  assign job_o  = hold_vld_q ? hold_job_q : job_a;

  // Stream state update.
  always_comb begin
    older_d     = older_q;
    older_vld_d = older_vld_q;
    pend_elem_d = pend_elem_q;
    pend_diag_d = pend_diag_q;
    pend_vld_d  = pend_vld_q;
    hold_vld_d  = hold_vld_q;
    hold_job_d  = hold_job_q;
    if (hold_vld_q && !full_i) begin
      hold_vld_d = 1'b0;
    end
    if (acc) begin
      priority if (is_last_i) begin
        older_vld_d = 1'b0;
        pend_vld_d  = 1'b0;
        if (pend_vld_q) begin
          hold_vld_d = 1'b1;
          hold_job_d = job_b;
        end
      end else if (!pend_vld_q) begin
        pend_elem_d = x;
        pend_diag_d = d;
        pend_vld_d  = 1'b1;
      end else begin
        older_d     = pend_elem_q;
        older_vld_d = 1'b1;
        pend_elem_d = x;
        pend_diag_d = d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_vld_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      hold_vld_q  <= 1'b0;
    end else begin
      older_vld_q <= older_vld_d;
      pend_vld_q  <= pend_vld_d;
      hold_vld_q  <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    older_q     <= older_d;
    pend_elem_q <= pend_elem_d;
    pend_diag_q <= pend_diag_d;
    hold_job_q  <= hold_job_d;
  end

`ifndef ASSERT_OFF
  // A held closing job means the vector has ended and its state is cleared.
  a_hold_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (!pend_vld_q && !older_vld_q))
    else $error("front: stream state not cleared while closing job held");

  // An older element only exists behind a pending one.
  a_older_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    older_vld_q |-> pend_vld_q)
    else $error("front: older element without pending element");

  // A held closing job is written into the queue while the queue is not
  // full, and the hold clears in the cycle after that write.
  a_hold_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_vld_q && !full_i) |=> !hold_vld_q)
    else $error("front: closing job not released");
`endif

endmodule

// File: rtl/core/tmq_job_fifo.sv
// ----------------------------------------------------------------------------
// Tridiagonal product job queue
// A short first-in first-out queue of product jobs that decouples the
// front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module tmq_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tmq_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tmq_pkg::job_t job_o
);
  import tmq_pkg::*;

  localparam int unsigned PtrW = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int unsigned CntW = $clog2(JobDepth + 1);

  job_t            mem_q [JobDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef ASSERT_OFF
  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job fifo: write while full");

  // The back end never reads from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job fifo: read while empty");

  // The fill count stays within the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(JobDepth))
    else $error("job fifo: fill count out of range");
`endif

endmodule

// File: rtl/core/tmq_back.sv
// ----------------------------------------------------------------------------
// Tridiagonal product back end
// Pipelined arithmetic: three coefficient products, saturated Q32.16 sum,
// quadratic term split into two partial products, and the saturating
// running quadratic-form accumulator feeding the output register.
// ----------------------------------------------------------------------------
module tmq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   next_coef_i,
  input  logic [31:0]   prev_coef_i,
  input  logic          empty_i,
  input  tmq_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [47:0]   prod_elem_o,
  output logic [63:0]   quad_sum_o,
  output logic          is_final_o
);
  import tmq_pkg::*;

  localparam int unsigned MulW = 2 * ElemW;
  localparam int unsigned SumW = MulW + 2;
  localparam int unsigned ShW  = SumW - 16;
  localparam int unsigned LoW  = ElemW + 17;

  logic adv;

  // Stage 1: coefficient products.
  logic                   s1_vld_q;
  logic signed [MulW-1:0] s1_p1_q, s1_p2_q, s1_p3_q;
  logic signed [ElemW-1:0] s1_v_q;
  logic                   s1_fin_q;

  // Stage 2: saturated product element.
  logic                    s2_vld_q;
  logic signed [ProdW-1:0] s2_prod_q, s2_prod_d;
  logic signed [ElemW-1:0] s2_v_q;
  logic                    s2_fin_q;
  logic signed [SumW-1:0]  sum3;
  logic signed [ShW-1:0]   sum3_sh;

  // Stage 3: partial products of the quadratic term.
  logic                    s3_vld_q;
  logic signed [MulW-1:0]  s3_hi_q;
  logic signed [LoW-1:0]   s3_lo_q;
  logic signed [ProdW-1:0] s3_prod_q;
  logic                    s3_fin_q;

  // Stage 4: quadratic term.
  logic                    s4_vld_q;
  logic signed [QuadW-1:0] s4_q_q;
  logic signed [ProdW-1:0] s4_prod_q;
  logic                    s4_fin_q;

  // Output register and accumulator.
  logic                    out_vld_q;
  logic [ProdW-1:0]        out_prod_q;
  logic [QuadW-1:0]        out_quad_q;
  logic                    out_fin_q;
  logic signed [QuadW-1:0] acc_q, acc_d;
  logic signed [QuadW:0]   acc_sum;
  logic signed [QuadW-1:0] acc_sat;

  // The whole pipe moves when the output register is free or being read.
  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Product-element sum, floor shift by 16 and saturation to 48 bits.
  assign sum3 = SumW'(s1_p1_q) + SumW'(s1_p2_q) + SumW'(s1_p3_q);
  assign sum3_sh = sum3[SumW-1:16];
  always_comb begin
    priority if (!sum3_sh[ShW-1] && (sum3_sh[ShW-2:ProdW-1] != '0)) begin
      s2_prod_d = {1'b0, {(ProdW-1){1'b1}}};
    end else if (sum3_sh[ShW-1] && (sum3_sh[ShW-2:ProdW-1] != '1)) begin
      s2_prod_d = {1'b1, {(ProdW-1){1'b0}}};
    end else begin
      s2_prod_d = sum3_sh[ProdW-1:0];
    end
  end

  // Saturating accumulation of the quadratic term.
  assign acc_sum = (QuadW+1)'(acc_q) + (QuadW+1)'(s4_q_q);
  always_comb begin
    if (acc_sum[QuadW] != acc_sum[QuadW-1]) begin
      acc_sat = acc_sum[QuadW] ? {1'b1, {(QuadW-1){1'b0}}} : {1'b0, {(QuadW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[QuadW-1:0];
    end
    acc_d = acc_q;
    if (adv && s4_vld_q) begin
      acc_d = s4_fin_q ? '0 : acc_sat;
    end
  end

  // Valid bits of the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      acc_q <= acc_d;
      if (adv) begin
        s1_vld_q  <= !empty_i;
        s2_vld_q  <= s1_vld_q;
        s3_vld_q  <= s2_vld_q;
        s4_vld_q  <= s3_vld_q;
        out_vld_q <= s4_vld_q;
      end
    end
  end

  // Pipe payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_p1_q   <= job_i.diag * job_i.elem;
      s1_p2_q   <= $signed(next_coef_i) * job_i.nbr_next;
      s1_p3_q   <= $signed(prev_coef_i) * job_i.nbr_prev;
      s1_v_q    <= job_i.elem;
      s1_fin_q  <= job_i.fin;

      s2_prod_q <= s2_prod_d;
      s2_v_q    <= s1_v_q;
      s2_fin_q  <= s1_fin_q;

      s3_hi_q   <= $signed(s2_prod_q[ProdW-1:16]) * s2_v_q;
      s3_lo_q   <= $signed({1'b0, s2_prod_q[15:0]}) * s2_v_q;
      s3_prod_q <= s2_prod_q;
      s3_fin_q  <= s2_fin_q;

      s4_q_q    <= s3_hi_q + {{(QuadW-LoW+16){s3_lo_q[LoW-1]}}, s3_lo_q[LoW-1:16]};
      s4_prod_q <= s3_prod_q;
      s4_fin_q  <= s3_fin_q;

      out_prod_q <= s4_prod_q;
      out_quad_q <= acc_sat;
      out_fin_q  <= s4_fin_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign prod_elem_o = out_prod_q;
  assign quad_sum_o  = out_quad_q;
  assign is_final_o  = out_fin_q;

`ifndef ASSERT_OFF
  // After the final element of a vector leaves stage four, the running
  // quadratic form starts again from zero.
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s4_vld_q && s4_fin_q) |=> (acc_q == '0))
    else $error("back: accumulator not cleared after final element");

  // A stage-four result always lands in the output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s4_vld_q) |=> out_vld_q)
    else $error("back: result lost at output register");

  // A job taken from the queue shows up in stage one.
  a_pop_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> s1_vld_q)
    else $error("back: popped job not in stage one");
`endif

endmodule
